[hdl/casenv_pkg.sv]
// Shared types and constants for the coil attack/sustain envelope block.
package casenv_pkg;

	localparam int HW_COIL_CAP  = 16;
	localparam int COIL_W       = 4;
	localparam int COUNT_W      = 5;

	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_SET  = 1'b1;

	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_ATTACK  = 2'd1,
		PH_SUSTAIN = 2'd2
	} phase_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_WALK = 1'b1
	} ctrl_state_t;

	typedef struct packed {
		logic              load_set;
		logic              latch_tick;
		logic              walk;
		logic              walk_last;
		logic [COIL_W-1:0] idx;
	} dp_cmd_t;

	typedef struct packed {
		logic [COUNT_W-1:0] n_eff;
		logic               set_ok;
	} dp_status_t;

endpackage

[hdl/coil_attack_sustain_envelope_top.sv]
// Top level of the coil attack/sustain envelope sequencer.
// Set word: accepted while idle, its result strobes on the next cycle (none for a bad coil).
// Tick word: the controller walks n active coils, one per cycle, and each result is
// registered before it strobes; busy is high throughout the walk.
// Results are strobed for one cycle each; the receiver cannot stall.
// Reset: all coils idle, active count 16, latest tick 0; no clearing pass.
module coil_attack_sustain_envelope_top #(
	parameter int MAX_COILS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        cmd,
	input  logic [31:0] tick_count,
	input  logic [7:0]  coil_index,
	input  logic [7:0]  attack_level,
	input  logic [7:0]  attack_time,
	input  logic [7:0]  sustain_level,
	input  logic [7:0]  sustain_time,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [4:0]  cfg_data,
	output logic        strobe,
	output logic [3:0]  out_coil,
	output logic [7:0]  drive_level,
	output logic        last
);

	localparam int NCOIL = (MAX_COILS < casenv_pkg::HW_COIL_CAP) ?
		MAX_COILS : casenv_pkg::HW_COIL_CAP;

	casenv_pkg::dp_cmd_t    dp_cmd;
	casenv_pkg::dp_status_t status;
	logic                   cfg_we;

	assign cfg_ready = ~busy;
	assign cfg_we    = cfg_valid & cfg_ready;

	casenv_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.status (status),
		.busy   (busy),
		.dp_cmd (dp_cmd)
	);

	casenv_dp #(
		.NCOIL (NCOIL)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.dp_cmd        (dp_cmd),
		.status        (status),
		.cfg_we        (cfg_we),
		.cfg_data      (cfg_data),
		.tick_count    (tick_count),
		.coil_index    (coil_index),
		.attack_level  (attack_level),
		.attack_time   (attack_time),
		.sustain_level (sustain_level),
		.sustain_time  (sustain_time),
		.strobe        (strobe),
		.out_coil      (out_coil),
		.drive_level   (drive_level),
		.last          (last)
	);

endmodule

[hdl/casenv_ctrl.sv]
// Controller: accepts items and sequences the walk over the active coils.
module casenv_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  cmd,
	input  casenv_pkg::dp_status_t status,
	output logic                  busy,
	output casenv_pkg::dp_cmd_t   dp_cmd
);

	casenv_pkg::ctrl_state_t state_q, state_d;
	logic [casenv_pkg::COIL_W-1:0] idx_q, idx_d;
	logic                           at_last;

	assign at_last = ((casenv_pkg::COUNT_W)'(idx_q) + 1'b1) == status.n_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= casenv_pkg::ST_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
		end
	end

	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		case (state_q)
			casenv_pkg::ST_IDLE: begin
				idx_d = '0;
				if (start && cmd == casenv_pkg::CMD_TICK && status.n_eff != '0) begin
					state_d = casenv_pkg::ST_WALK;
				end
			end
			casenv_pkg::ST_WALK: begin
				idx_d = idx_q + 1'b1;
				if (at_last) begin
					state_d = casenv_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = casenv_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		busy              = 1'b0;
		dp_cmd.load_set   = 1'b0;
		dp_cmd.latch_tick = 1'b0;
		dp_cmd.walk       = 1'b0;
		dp_cmd.walk_last  = 1'b0;
		dp_cmd.idx        = idx_q;
		case (state_q)
			casenv_pkg::ST_IDLE: begin
				dp_cmd.latch_tick = start && cmd == casenv_pkg::CMD_TICK;
				dp_cmd.load_set   = start && cmd == casenv_pkg::CMD_SET && status.set_ok;
			end
			casenv_pkg::ST_WALK: begin
				busy             = 1'b1;
				dp_cmd.walk      = 1'b1;
				dp_cmd.walk_last = at_last;
			end
			default: begin
				busy = 1'b0;
			end
		endcase
	end

endmodule

[hdl/casenv_dp.sv]
// Datapath: per-coil envelope store, phase update and result register.
module casenv_dp #(
	parameter int NCOIL = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  casenv_pkg::dp_cmd_t                 dp_cmd,
	output casenv_pkg::dp_status_t              status,
	input  logic                                cfg_we,
	input  logic [casenv_pkg::COUNT_W-1:0]      cfg_data,
	input  logic [31:0]                         tick_count,
	input  logic [7:0]                          coil_index,
	input  logic [7:0]                          attack_level,
	input  logic [7:0]                          attack_time,
	input  logic [7:0]                          sustain_level,
	input  logic [7:0]                          sustain_time,
	output logic                                strobe,
	output logic [casenv_pkg::COIL_W-1:0]       out_coil,
	output logic [7:0]                          drive_level,
	output logic                                last
);

	localparam int IDXW = (NCOIL > 1) ? $clog2(NCOIL) : 1;
	localparam logic [casenv_pkg::COUNT_W-1:0] NCOIL_N = (casenv_pkg::COUNT_W)'(NCOIL);

	logic [7:0]  al_q [NCOIL];
	logic [7:0]  at_q [NCOIL];
	logic [7:0]  sl_q [NCOIL];
	logic [7:0]  st_q [NCOIL];
	logic [31:0] start_q [NCOIL];
	casenv_pkg::phase_t ph_q [NCOIL];

	logic [casenv_pkg::COUNT_W-1:0] active_q;
	logic [31:0]                    latest_q;

	logic [IDXW-1:0]    set_idx, walk_idx;
	logic [31:0]        elapsed;
	logic               attack_done, sustain_done;
	logic [7:0]         walk_level;
	casenv_pkg::phase_t walk_ph;

	logic                           strobe_q, last_q;
	logic [casenv_pkg::COIL_W-1:0]  coil_q;
	logic [7:0]                     level_q;

	// true once elapsed has reached t*10 ticks; zero duration never ends
	function automatic logic time_hit(input logic [31:0] el, input logic [7:0] t);
		logic [11:0] scaled;
		scaled = {1'b0, t, 3'b000} + {3'b000, t, 1'b0};
		return (t != 8'd0) && ((el[31:12] != '0) || (el[11:0] >= scaled));
	endfunction

	assign status.n_eff  = (active_q > NCOIL_N) ? NCOIL_N : active_q;
	assign status.set_ok = coil_index < {3'b000, status.n_eff};

	assign set_idx  = coil_index[IDXW-1:0];
	assign walk_idx = dp_cmd.idx[IDXW-1:0];

	assign elapsed      = latest_q - start_q[walk_idx];
	assign attack_done  = time_hit(elapsed, at_q[walk_idx]);
	assign sustain_done = time_hit(elapsed, st_q[walk_idx]);

	always_comb begin
		case (ph_q[walk_idx])
			casenv_pkg::PH_ATTACK: begin
				if (attack_done) begin
					walk_level = sl_q[walk_idx];
					walk_ph    = casenv_pkg::PH_SUSTAIN;
				end else begin
					walk_level = al_q[walk_idx];
					walk_ph    = casenv_pkg::PH_ATTACK;
				end
			end
			casenv_pkg::PH_SUSTAIN: begin
				if (sustain_done) begin
					walk_level = 8'd0;
					walk_ph    = casenv_pkg::PH_IDLE;
				end else begin
					walk_level = sl_q[walk_idx];
					walk_ph    = casenv_pkg::PH_SUSTAIN;
				end
			end
			default: begin
				walk_level = 8'd0;
				walk_ph    = casenv_pkg::PH_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= (casenv_pkg::COUNT_W)'(casenv_pkg::HW_COIL_CAP);
			latest_q <= '0;
			strobe_q <= 1'b0;
			for (int i = 0; i < NCOIL; i++) begin
				ph_q[i] <= casenv_pkg::PH_IDLE;
			end
		end else begin
			if (cfg_we) begin
				active_q <= cfg_data;
			end
			if (dp_cmd.latch_tick) begin
				latest_q <= tick_count;
			end
			strobe_q <= dp_cmd.load_set | dp_cmd.walk;
			if (dp_cmd.load_set) begin
				ph_q[set_idx] <= casenv_pkg::PH_ATTACK;
			end else if (dp_cmd.walk) begin
				ph_q[walk_idx] <= walk_ph;
			end
		end
	end

	// envelope words and result word carry no reset
	always_ff @(posedge clk) begin
		if (dp_cmd.load_set) begin
			al_q[set_idx]    <= attack_level;
			at_q[set_idx]    <= attack_time;
			sl_q[set_idx]    <= sustain_level;
			st_q[set_idx]    <= sustain_time;
			start_q[set_idx] <= latest_q;
			coil_q           <= coil_index[casenv_pkg::COIL_W-1:0];
			level_q          <= attack_level;
			last_q           <= 1'b1;
		end else if (dp_cmd.walk) begin
			coil_q  <= dp_cmd.idx;
			level_q <= walk_level;
			last_q  <= dp_cmd.walk_last;
		end
	end

	assign strobe      = strobe_q;
	assign out_coil    = coil_q;
	assign drive_level = level_q;
	assign last        = last_q;

endmodule
